// ===== rtl/ddo_pkg.sv =====
`default_nettype none

package ddo_pkg;

    // Defaults for the top-level parameters
    localparam int CORDIC_STEPS_DEF  = 20;
    localparam int POS_FRAC_BITS_DEF = 16;
    localparam int HEADING_BITS_DEF  = 24;

    // CORDIC datapath width (Q30 vectors, Q32-turn angles)
    localparam int CW = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic signed [CW-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [CW-1:0] HALF_TURN    = 34'sd2147483648;

    // 1/pi as a Q64 fraction, and its top 30 bits for the fractional product
    localparam logic [63:0] INV_PI_Q64 = 64'h517C_C1B7_2722_0A95;
    localparam logic [29:0] INV_PI_HI  = 30'(INV_PI_Q64 >> 34);

    // Arc divisor: 360 degrees times 2 (mean) times 1e6 um per metre
    localparam logic [29:0] ARC_DIV   = 30'd720000000;
    localparam logic [8:0]  SENS_DIV  = 9'd360;
    localparam logic [8:0]  SENS_RND  = 9'd180;
    localparam logic [6:0]  RANGE_DIV = 7'd100;

    // Step length limit, +-2^32 LSB
    localparam int STEP_W = 34;
    localparam logic signed [STEP_W-1:0] STEP_LIM = 34'sh1_0000_0000;

    // Width of a pose sum before saturation
    localparam int SUM_W = 39;

    // Configuration register map
    typedef enum logic [1:0] {
        REG_WHEEL_CIRC  = 2'd0,
        REG_WHEEL_OFF   = 2'd1,
        REG_MIN_RANGE   = 2'd2,
        REG_MAX_RANGE   = 2'd3
    } cfg_reg_t;

    localparam logic [21:0] WHEEL_CIRC_RST = 22'd176000;
    localparam logic [21:0] WHEEL_OFF_RST  = 22'd60000;
    localparam logic [9:0]  MIN_RANGE_RST  = 10'd5;
    localparam logic [9:0]  MAX_RANGE_RST  = 10'd60;

    // atan(2^-i) in Q32 turns
    function automatic logic [29:0] atan_q32(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Clamp a pose sum to 32-bit signed
    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] r;
        if ((v[SUM_W-1:31] == '0) || (v[SUM_W-1:31] == '1))
            r = v[31:0];
        else if (v[SUM_W-1])
            r = 32'sh8000_0000;
        else
            r = 32'sh7FFF_FFFF;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ddo_smul.sv =====
`default_nettype none

// Serial signed multiplier: one multiplier bit per cycle, product mod 2^P_W.
module ddo_smul #(
    parameter int A_W = 34,
    parameter int B_W = 23,
    parameter int P_W = 57
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [A_W-1:0] a,
    input  logic signed [B_W-1:0] b,
    output logic signed [P_W-1:0] prod,
    output logic                  done
);

    localparam int CNT_W = $clog2(B_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [P_W-1:0]   mcand_reg;
    logic [B_W-1:0]   mplier_reg;
    logic [P_W-1:0]   acc_reg;
    logic             last;
    logic [P_W-1:0]   addend;
    logic [P_W-1:0]   acc_next;

    always_comb
    begin
        last     = (cnt_reg == CNT_W'(B_W - 1));
        addend   = mplier_reg[0] ? mcand_reg : '0;
        // top bit of a signed multiplier carries negative weight
        acc_next = last ? acc_reg - addend : acc_reg + addend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= P_W'(a);
            mplier_reg <= b;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_next;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/ddo_udiv.sv =====
`default_nettype none

// Restoring unsigned divider: one quotient bit per cycle.
module ddo_udiv #(
    parameter int N_W = 42,
    parameter int D_W = 9
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic [N_W-1:0] quo,
    output logic [D_W-1:0] rem,
    output logic           done
);

    localparam int CNT_W = $clog2(N_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [N_W-1:0]   quo_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   den_reg;
    logic             last;
    logic [D_W:0]     trial;
    logic             ge;
    logic [D_W-1:0]   rem_next;

    always_comb
    begin
        last     = (cnt_reg == CNT_W'(N_W - 1));
        trial    = {rem_reg, quo_reg[N_W-1]};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? D_W'(trial - {1'b0, den_reg}) : trial[D_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            // dividend bits shift out the top, quotient bits shift in below
            quo_reg <= {quo_reg[N_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/ddo_cordic.sv =====
`default_nettype none

// Iterative rotation CORDIC, one micro-rotation per cycle.
module ddo_cordic
    import ddo_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          ang,
    output logic signed [CW-1:0] cos_out,
    output logic signed [CW-1:0] sin_out,
    output logic                 done
);

    localparam int N_IT = (STEPS > 32) ? 32 : STEPS;

    logic                 busy_reg;
    logic                 done_reg;
    logic [4:0]           it_reg;
    logic                 flip_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [CW-1:0] z_reg;
    logic signed [CW-1:0] z_in;
    logic signed [CW-1:0] z_fold;
    logic                 flip_in;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] at;
    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    logic signed [CW-1:0] z_next;
    logic                 last;

    always_comb
    begin
        // fold the angle into the right half-plane
        z_in    = CW'($signed(ang));
        z_fold  = z_in;
        flip_in = 1'b0;
        if (z_in > QUARTER_TURN)
        begin
            z_fold  = z_in - HALF_TURN;
            flip_in = 1'b1;
        end
        else if (z_in < -QUARTER_TURN)
        begin
            z_fold  = z_in + HALF_TURN;
            flip_in = 1'b1;
        end
    end

    always_comb
    begin
        last = (it_reg == 5'(N_IT - 1));
        xs   = x_reg >>> it_reg;
        ys   = y_reg >>> it_reg;
        at   = CW'(atan_q32(it_reg));
        if (!z_reg[CW-1])
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - at;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                it_reg   <= '0;
            end
            else if (busy_reg)
            begin
                it_reg <= it_reg + 1'b1;
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= z_fold;
            flip_reg <= flip_in;
        end
        else if (busy_reg)
        begin
            z_reg <= z_next;
            // undo the fold on the final rotation
            if (last && flip_reg)
            begin
                x_reg <= -x_next;
                y_reg <= -y_next;
            end
            else
            begin
                x_reg <= x_next;
                y_reg <= y_next;
            end
        end
    end

    assign cos_out = x_reg;
    assign sin_out = y_reg;
    assign done    = done_reg;

endmodule

`default_nettype wire

// ===== rtl/diff_drive_odometry_range_point_unit.sv =====
`default_nettype none

// Dead-reckoning odometry for a differential-drive robot. Each input transaction carries
// the cumulative left and right wheel angles in degrees; the unit differences them against
// the previous transaction, turns the difference of the wheel arcs into a heading change
// (binary angle, wraps) and then moves x and y (Q16.16 metres, saturating) by the mean arc
// along the new heading. With tuser set, a range sample strictly between the configured
// minimum and maximum is projected from the new pose along heading minus sensor bearing
// and returned with the point flag in tuser; otherwise the point fields read zero.
// One transaction is processed at a time. The pose path runs two serial products side by
// side, a bit-serial division (the heading quotient, 56 + 30 bits), a serial product by
// 1/pi, one CORDIC pass and a serial product; each of these hands over to the next, and
// the output register is loaded last. The projection adds a second CORDIC pass and
// product. The input is ready again in the cycle after the output load. The next input
// transaction is taken once the result has moved into the output register, even if it is
// not yet taken.
// Configuration writes take effect at once and must be issued only while the unit is idle.
module diff_drive_odometry_range_point_unit
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
    parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF,
    parameter int HEADING_BITS  = HEADING_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,

    // configuration write port
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [21:0]  cfg_wdata,

    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [87:0]  s_axis_tdata,   // left_wheel_deg, right_wheel_deg,
                                         // sensor_angle_deg, range_cm, zero pad
    input  logic         s_axis_tuser,   // func

    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [151:0] m_axis_tdata,   // pos_x, pos_y, heading, point_x, point_y
    output logic         m_axis_tuser    // point_valid
);

    // Widths of the magnitude of a wheel product and of the two scaled quotients
    localparam int MAG_W = 56;
    localparam int HF    = 30;
    localparam int DH_N  = MAG_W + HF;
    localparam int DA_N  = MAG_W + POS_FRAC_BITS;
    localparam int DD_N  = 10 + POS_FRAC_BITS;
    localparam int P_W   = 57;
    localparam int XP_W  = STEP_W + CW;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL   = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_TURN  = 9'b000001000,
        S_COR1  = 9'b000010000,
        S_PMUL  = 9'b000100000,
        S_COR2  = 9'b001000000,
        S_PMUL2 = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration
    logic [21:0] circ_reg;
    logic [21:0] off_reg;
    logic [9:0]  min_reg;
    logic [9:0]  max_reg;

    // odometry state
    logic signed [31:0]        last_left_reg;
    logic signed [31:0]        last_right_reg;
    logic signed [31:0]        pose_x_reg;
    logic signed [31:0]        pose_y_reg;
    logic [HEADING_BITS-1:0]   heading_reg;

    // per-transaction working registers
    logic [32:0]               m_reg;
    logic                      valid_reg;
    logic                      sens_neg_reg;
    logic                      neg_h_reg;
    logic                      neg_a_reg;
    logic signed [STEP_W-1:0]  step_reg;
    logic signed [31:0]        point_x_reg;
    logic signed [31:0]        point_y_reg;

    // output register
    logic                      m_valid_reg;
    logic [151:0]              m_data_reg;
    logic                      m_user_reg;

    // input decode
    logic                      accept;
    logic signed [31:0]        left_deg;
    logic signed [31:0]        right_deg;
    logic signed [9:0]         sens_deg;
    logic [9:0]                range_cm;
    logic signed [32:0]        dl;
    logic signed [32:0]        dr;
    logic signed [33:0]        wdiff;
    logic signed [33:0]        wsum;
    logic signed [22:0]        circ_s;
    logic [21:0]               off_eff;
    logic [32:0]               m_in;
    logic [9:0]                sens_mag;
    logic [41:0]               sens_num;

    // unit handshakes and results
    logic                      p_done;
    logic signed [P_W-1:0]     p1_prod;
    logic signed [P_W-1:0]     p2_prod;
    logic signed [P_W-1:0]     p1_mag;
    logic signed [P_W-1:0]     p2_mag;
    logic                      div_start;
    logic                      dh_done;
    logic [DH_N-1:0]           dh_quo;
    logic [32:0]               dh_rem;
    logic [DA_N-1:0]           da_quo;
    logic [29:0]               da_rem;
    logic [41:0]               ds_quo;
    logic [DD_N-1:0]           dd_quo;
    logic signed [DH_N:0]      qh;
    logic signed [DA_N:0]      qa;
    logic signed [63:0]        q64;
    logic signed [30:0]        f31;
    logic                      turn_start;
    logic                      ta_done;
    logic signed [63:0]        ta_prod;
    logic signed [61:0]        tb_prod;
    logic [63:0]               turn;
    logic [63:0]               turn_rnd;
    logic [HEADING_BITS-1:0]   dh;
    logic [HEADING_BITS-1:0]   heading_new;
    logic [31:0]               hq_new;
    logic [31:0]               hq_cur;
    logic [31:0]               pt_ang;
    logic signed [STEP_W-1:0]  step_sat;
    logic                      cor_start;
    logic [31:0]               cor_ang;
    logic                      cor_done;
    logic signed [CW-1:0]      cos_v;
    logic signed [CW-1:0]      sin_v;
    logic                      pm_start;
    logic signed [STEP_W-1:0]  pm_a;
    logic                      x_done;
    logic signed [XP_W-1:0]    x_prod;
    logic signed [XP_W-1:0]    y_prod;
    logic signed [SUM_W-1:0]   x_sum;
    logic signed [SUM_W-1:0]   y_sum;
    logic                      out_load;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // input field decode and wheel deltas
    always_comb
    begin
        left_deg  = $signed(s_axis_tdata[31:0]);
        right_deg = $signed(s_axis_tdata[63:32]);
        sens_deg  = $signed(s_axis_tdata[73:64]);
        range_cm  = s_axis_tdata[83:74];
        dl        = 33'(left_deg) - 33'(last_left_reg);
        dr        = 33'(right_deg) - 33'(last_right_reg);
        wdiff     = 34'(dr) - 34'(dl);
        wsum      = 34'(dl) + 34'(dr);
        circ_s    = $signed({1'b0, circ_reg});
        // a zero wheel offset counts as one
        off_eff   = (off_reg == '0) ? 22'd1 : off_reg;
        // 1440 * offset by shift-add
        m_in      = (33'(off_eff) << 10) + (33'(off_eff) << 8)
                  + (33'(off_eff) << 7) + (33'(off_eff) << 5);
        sens_mag  = sens_deg[9] ? 10'(-sens_deg) : 10'(sens_deg);
        // bearing in Q32 turns, rounded half away from zero
        sens_num  = {sens_mag, 32'd0} + 42'(SENS_RND);
    end

    // wheel arcs: difference and sum of wheel deltas times circumference
    ddo_smul #(.A_W(34), .B_W(23), .P_W(P_W)) u_mul_diff (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .a     (wdiff),
        .b     (circ_s),
        .prod  (p1_prod),
        .done  (p_done)
    );

    ddo_smul #(.A_W(34), .B_W(23), .P_W(P_W)) u_mul_sum (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .a     (wsum),
        .b     (circ_s),
        .prod  (p2_prod),
        .done  ()
    );

    // sensor bearing and range scaling run alongside the odometry path
    ddo_udiv #(.N_W(42), .D_W(9)) u_div_sens (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .num   (sens_num),
        .den   (SENS_DIV),
        .quo   (ds_quo),
        .rem   (),
        .done  ()
    );

    ddo_udiv #(.N_W(DD_N), .D_W(7)) u_div_range (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .num   ({range_cm, {POS_FRAC_BITS{1'b0}}}),
        .den   (RANGE_DIV),
        .quo   (dd_quo),
        .rem   (),
        .done  ()
    );

    // divide magnitudes; the sign is restored with floor semantics afterwards
    always_comb
    begin
        p1_mag    = p1_prod[P_W-1] ? -p1_prod : p1_prod;
        p2_mag    = p2_prod[P_W-1] ? -p2_prod : p2_prod;
        div_start = (state_reg == S_MUL) && p_done;
    end

    ddo_udiv #(.N_W(DH_N), .D_W(33)) u_div_head (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({p1_mag[MAG_W-1:0], {HF{1'b0}}}),
        .den   (m_reg),
        .quo   (dh_quo),
        .rem   (dh_rem),
        .done  (dh_done)
    );

    ddo_udiv #(.N_W(DA_N), .D_W(30)) u_div_arc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({p2_mag[MAG_W-1:0], {POS_FRAC_BITS{1'b0}}}),
        .den   (ARC_DIV),
        .quo   (da_quo),
        .rem   (da_rem),
        .done  ()
    );

    // floored signed quotients; heading keeps 30 fraction bits, arc is the step length
    always_comb
    begin
        qh = neg_h_reg ? -($signed({1'b0, dh_quo})) - (DH_N + 1)'(dh_rem != '0)
                       : $signed({1'b0, dh_quo});
        qa = neg_a_reg ? -($signed({1'b0, da_quo})) - (DA_N + 1)'(da_rem != '0)
                       : $signed({1'b0, da_quo});
        q64 = 64'(qh >>> HF);
        f31 = $signed({1'b0, qh[HF-1:0]});
        if (qa > (DA_N + 1)'(STEP_LIM))
            step_sat = STEP_LIM;
        else if (qa < -((DA_N + 1)'(STEP_LIM)))
            step_sat = -STEP_LIM;
        else
            step_sat = STEP_W'(qa);
        turn_start = (state_reg == S_DIV) && dh_done;
    end

    // heading increment in turns: integer part times 1/pi plus fraction times 1/pi
    ddo_smul #(.A_W(64), .B_W(64), .P_W(64)) u_mul_turn_int (
        .clk   (clk),
        .rst_n (rst_n),
        .start (turn_start),
        .a     (q64),
        .b     ($signed(INV_PI_Q64)),
        .prod  (ta_prod),
        .done  (ta_done)
    );

    ddo_smul #(.A_W(31), .B_W(31), .P_W(62)) u_mul_turn_frac (
        .clk   (clk),
        .rst_n (rst_n),
        .start (turn_start),
        .a     (f31),
        .b     ($signed({1'b0, INV_PI_HI})),
        .prod  (tb_prod),
        .done  ()
    );

    always_comb
    begin
        turn        = ta_prod + {tb_prod[59:0], 4'd0};
        turn_rnd    = turn + (64'd1 << (63 - HEADING_BITS));
        dh          = HEADING_BITS'(turn_rnd >> (64 - HEADING_BITS));
        heading_new = heading_reg + dh;
        hq_new      = 32'(heading_new) << (32 - HEADING_BITS);
        hq_cur      = 32'(heading_reg) << (32 - HEADING_BITS);
        pt_ang      = sens_neg_reg ? hq_cur + ds_quo[31:0] : hq_cur - ds_quo[31:0];
    end

    // one CORDIC serves the pose heading and then the sensor ray
    always_comb
    begin
        cor_start = ((state_reg == S_TURN) && ta_done)
                 || ((state_reg == S_PMUL) && x_done && valid_reg);
        cor_ang   = (state_reg == S_TURN) ? hq_new : pt_ang;
        pm_start  = ((state_reg == S_COR1) || (state_reg == S_COR2)) && cor_done;
        pm_a      = (state_reg == S_COR2) ? STEP_W'(dd_quo) : step_reg;
    end

    ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .ang     (cor_ang),
        .cos_out (cos_v),
        .sin_out (sin_v),
        .done    (cor_done)
    );

    // projections: step length for the pose, range for the point
    ddo_smul #(.A_W(STEP_W), .B_W(CW), .P_W(XP_W)) u_mul_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pm_start),
        .a     (pm_a),
        .b     (cos_v),
        .prod  (x_prod),
        .done  (x_done)
    );

    ddo_smul #(.A_W(STEP_W), .B_W(CW), .P_W(XP_W)) u_mul_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pm_start),
        .a     (pm_a),
        .b     (sin_v),
        .prod  (y_prod),
        .done  ()
    );

    // floor shift by 30, add to the pose; both projections share this adder
    always_comb
    begin
        x_sum = SUM_W'(pose_x_reg) + SUM_W'($signed(x_prod[XP_W-1:30]));
        y_sum = SUM_W'(pose_y_reg) + SUM_W'($signed(y_prod[XP_W-1:30]));
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                if (p_done)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (dh_done)
                    state_next = S_TURN;
            end
            S_TURN:
            begin
                if (ta_done)
                    state_next = S_COR1;
            end
            S_COR1:
            begin
                if (cor_done)
                    state_next = S_PMUL;
            end
            S_PMUL:
            begin
                if (x_done)
                    state_next = valid_reg ? S_COR2 : S_OUT;
            end
            S_COR2:
            begin
                if (cor_done)
                    state_next = S_PMUL2;
            end
            S_PMUL2:
            begin
                if (x_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state, configuration and odometry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            circ_reg       <= WHEEL_CIRC_RST;
            off_reg        <= WHEEL_OFF_RST;
            min_reg        <= MIN_RANGE_RST;
            max_reg        <= MAX_RANGE_RST;
            last_left_reg  <= '0;
            last_right_reg <= '0;
            pose_x_reg     <= '0;
            pose_y_reg     <= '0;
            heading_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_WHEEL_CIRC: circ_reg <= cfg_wdata;
                    REG_WHEEL_OFF:  off_reg  <= cfg_wdata;
                    REG_MIN_RANGE:  min_reg  <= cfg_wdata[9:0];
                    REG_MAX_RANGE:  max_reg  <= cfg_wdata[9:0];
                    default:        ;
                endcase
            end

            if (accept)
            begin
                last_left_reg  <= left_deg;
                last_right_reg <= right_deg;
            end

            // heading advances before x and y
            if ((state_reg == S_TURN) && ta_done)
                heading_reg <= heading_new;

            if ((state_reg == S_PMUL) && x_done)
            begin
                pose_x_reg <= sat32(x_sum);
                pose_y_reg <= sat32(y_sum);
            end

            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // per-transaction payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_reg        <= m_in;
            sens_neg_reg <= sens_deg[9];
            valid_reg    <= s_axis_tuser && (range_cm > min_reg) && (range_cm < max_reg);
        end

        if (div_start)
        begin
            neg_h_reg <= p1_prod[P_W-1];
            neg_a_reg <= p2_prod[P_W-1];
        end

        if (turn_start)
            step_reg <= step_sat;

        if ((state_reg == S_PMUL2) && x_done)
        begin
            point_x_reg <= sat32(x_sum);
            point_y_reg <= sat32(y_sum);
        end

        if (out_load)
        begin
            m_data_reg <= {valid_reg ? point_y_reg : 32'sd0,
                           valid_reg ? point_x_reg : 32'sd0,
                           24'(heading_reg),
                           pose_y_reg,
                           pose_x_reg};
            m_user_reg <= valid_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

`default_nettype wire
